[rtl/wfd_pkg.sv]
`timescale 1ns / 1ps

package wfd_pkg;

    // frame geometry
    localparam int BYTE_W    = 8;
    localparam int FRAME_LEN = 11;
    localparam int MAG_W     = 24;
    localparam int DELTA_W   = MAG_W + 1;
    localparam int OUT_W     = 56;

    // frame byte positions, oldest byte first
    localparam int HDR0_POS  = 0;
    localparam int HDR1_POS  = 1;
    localparam int LSIGN_POS = 2;
    localparam int LMAG_POS  = 3;
    localparam int RSIGN_POS = 6;
    localparam int RMAG_POS  = 7;
    localparam int CSUM_POS  = 10;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;

    // element 0 is the oldest byte
    typedef logic [FRAME_LEN-1:0][BYTE_W-1:0] frame_t;

    // result of checking one window
    typedef struct packed {
        logic                      ok;
        logic signed [DELTA_W-1:0] left_delta;
        logic signed [DELTA_W-1:0] right_delta;
    } check_t;

endpackage

[rtl/wfd_window.sv]
`timescale 1ns / 1ps

module wfd_window
    import wfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              advance,
    output frame_t            frame,
    output logic              frame_valid
);

    frame_t win_reg, win_next;
    logic   valid_reg, valid_next;
    logic   accept;

    // a held window leaves when the next stage takes or drops it
    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // shift in the new byte, drop the oldest
    always_comb begin
        win_next = win_reg;
        if (accept) begin
            win_next = {s_tdata, win_reg[FRAME_LEN-1:1]};
        end
    end

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            win_reg   <= win_next;
            valid_reg <= valid_next;
        end
    end

    assign frame       = win_reg;
    assign frame_valid = valid_reg;

endmodule

[rtl/wfd_check.sv]
`timescale 1ns / 1ps

module wfd_check
    import wfd_pkg::*;
(
    input  frame_t frame,
    output check_t result
);

    // sign byte nonzero means positive, zero means negative
    function automatic logic signed [DELTA_W-1:0] decode_delta(
        input logic [BYTE_W-1:0] sign_byte,
        input logic [MAG_W-1:0]  mag
    );
        logic signed [DELTA_W-1:0] ext;
        begin
            ext = $signed({1'b0, mag});
            decode_delta = (sign_byte != '0) ? ext : -ext;
        end
    endfunction

    logic [BYTE_W-1:0] s01, s23, s45, s67, s89;
    logic [BYTE_W-1:0] s03, s47, s07, csum;
    logic              hdr_ok;

    // wrapping sum of the first ten bytes as a small tree
    always_comb begin
        s01  = frame[0] + frame[1];
        s23  = frame[2] + frame[3];
        s45  = frame[4] + frame[5];
        s67  = frame[6] + frame[7];
        s89  = frame[8] + frame[9];
        s03  = s01 + s23;
        s47  = s45 + s67;
        s07  = s03 + s47;
        csum = s07 + s89;
    end

    assign hdr_ok = (frame[HDR0_POS] == HDR_BYTE) && (frame[HDR1_POS] == HDR_BYTE);

    // big-endian magnitudes follow each sign byte
    always_comb begin
        result.ok          = hdr_ok && (csum == frame[CSUM_POS]);
        result.left_delta  = decode_delta(frame[LSIGN_POS],
            {frame[LMAG_POS], frame[LMAG_POS+1], frame[LMAG_POS+2]});
        result.right_delta = decode_delta(frame[RSIGN_POS],
            {frame[RMAG_POS], frame[RMAG_POS+1], frame[RMAG_POS+2]});
    end

endmodule

[rtl/wheel_feedback_frame_deframer_core.sv]
`timescale 1ns / 1ps

// Wheel feedback deframer: takes one serial byte per request and checks the
// eleven-byte window that each byte closes (two 0xFF header bytes, two sign +
// 24-bit big-endian magnitude fields, 8-bit additive checksum). A window that
// passes gives one result with both wheel deltas as 25-bit two's complement;
// any other window gives nothing. One byte is taken every cycle while the
// output keeps up; a good frame waiting on a stalled output holds the input.
// A closing byte is taken into the window register, and the checksum adder tree
// feeds the output register, where the result is presented. The window starts
// as zeros after reset, so no frame is reported before a full header and
// payload have arrived.
module wheel_feedback_frame_deframer_core
    import wfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // [24:0] left_delta, [49:25] right_delta
);

    frame_t frame;
    logic   frame_valid;
    logic   advance;
    logic   out_load;
    check_t check;

    logic                      m_valid_reg, m_valid_next;
    logic signed [DELTA_W-1:0] left_reg, left_next;
    logic signed [DELTA_W-1:0] right_reg, right_next;

    wfd_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .advance     (advance),
        .frame       (frame),
        .frame_valid (frame_valid)
    );

    wfd_check u_check (
        .frame  (frame),
        .result (check)
    );

    // bad windows drop at once, good ones wait for room in the output register
    assign advance  = !m_valid_reg || m_tready || !check.ok;
    assign out_load = frame_valid && check.ok && (!m_valid_reg || m_tready);

    always_comb begin
        left_next  = left_reg;
        right_next = right_reg;
        if (out_load) begin
            left_next  = check.left_delta;
            right_next = check.right_delta;
        end
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_W - 2*DELTA_W){1'b0}}, right_reg, left_reg};

    // a taken byte is always held in the window stage next cycle
    a_accept_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> frame_valid)
        else $error("accepted byte not held in window stage");

    // only a window with both header bytes reaches the output
    a_load_header: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (frame[HDR0_POS] == HDR_BYTE && frame[HDR1_POS] == HDR_BYTE))
        else $error("result loaded without frame header");

    // sign-magnitude decode never yields the most negative code
    a_delta_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (left_reg != {1'b1, {(DELTA_W-1){1'b0}}}
                      && right_reg != {1'b1, {(DELTA_W-1){1'b0}}}))
        else $error("delta outside sign-magnitude range");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !out_load)
        else $error("pending result overwritten");

    // reset empties both stages
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !frame_valid))
        else $error("stage valid after reset");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import wfd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 120;
    localparam int RANDOM_ITEMS = 550;
    localparam int DRAIN_CYCLES = 16;

    // one decoded frame: both wheel deltas
    typedef struct {
        logic signed [DELTA_W-1:0] left;
        logic signed [DELTA_W-1:0] right;
    } wheel_deltas_t;

    // tracks the byte window and the deltas still owed by the block
    class wheel_delta_board;
        logic [BYTE_W-1:0] win [FRAME_LEN-1];
        wheel_deltas_t     deltas_due [$];
        int                errors;
        int                bytes_taken;

        function new();
            foreach (win[i]) win[i] = '0;
            errors      = 0;
            bytes_taken = 0;
        endfunction

        function logic signed [DELTA_W-1:0] decode_delta(logic [BYTE_W-1:0] sign_b,
                                                         logic [MAG_W-1:0]  mag);
            logic [DELTA_W-1:0] wide;
            wide = {1'b0, mag};
            // zero sign byte means negative
            return (sign_b != '0) ? wide : -wide;
        endfunction

        // a byte went in: test the window it closes, then shift
        function void note_byte(logic [BYTE_W-1:0] rx);
            logic [BYTE_W-1:0] csum;
            wheel_deltas_t     d;
            csum = '0;
            for (int i = 0; i < FRAME_LEN - 1; i++) csum += win[i];
            if (win[HDR0_POS] == HDR_BYTE && win[HDR1_POS] == HDR_BYTE && csum == rx) begin
                d.left  = decode_delta(win[LSIGN_POS],
                                       {win[LMAG_POS], win[LMAG_POS+1], win[LMAG_POS+2]});
                d.right = decode_delta(win[RSIGN_POS],
                                       {win[RMAG_POS], win[RMAG_POS+1], win[RMAG_POS+2]});
                deltas_due.push_back(d);
            end
            for (int i = 0; i < FRAME_LEN - 2; i++) win[i] = win[i+1];
            win[FRAME_LEN-2] = rx;
            bytes_taken++;
        endfunction

        function int pending();
            return deltas_due.size();
        endfunction

        task report(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            errors++;
        endtask

        // a result came out: compare with the oldest frame owed
        task check_result(logic [OUT_W-1:0] data);
            logic signed [DELTA_W-1:0] got_left;
            logic signed [DELTA_W-1:0] got_right;
            wheel_deltas_t             want;
            got_left  = data[DELTA_W-1:0];
            got_right = data[2*DELTA_W-1:DELTA_W];
            if (deltas_due.size() == 0) begin
                report($sformatf("unexpected result left=%0d right=%0d",
                                 got_left, got_right));
            end else begin
                want = deltas_due.pop_front();
                if (got_left !== want.left)
                    report($sformatf("left_delta got %0d want %0d", got_left, want.left));
                if (got_right !== want.right)
                    report($sformatf("right_delta got %0d want %0d", got_right, want.right));
            end
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;    // [7:0] rx_byte
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;         // [24:0] left_delta, [49:25] right_delta

    wheel_delta_board  board = new();
    logic [BYTE_W-1:0] rx_q [$];
    int                cycle_count = 0;
    int                hold_left = 0;
    bit                hold_done = 1'b0;
    int                ready_phase = 0;
    int                ready_mode = 0;

    wheel_feedback_frame_deframer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    // receiver: changing stall patterns plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!hold_done && board.bytes_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (ready_phase % 48 == 0) ready_mode = $urandom_range(0, 3);
            ready_phase++;
            case (ready_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_tready <= (ready_phase % 4 == 0);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 7) != 0);
                end
            endcase
        end
    end

    // payload byte leaning toward the extremes
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_sign();
        return $urandom_range(0, 1) ? 8'h00 : pick_byte() | 8'h01;
    endfunction

    // queue one frame, optionally with a broken checksum
    function automatic void push_frame(logic [BYTE_W-1:0] lsign, logic [MAG_W-1:0] lmag,
                                       logic [BYTE_W-1:0] rsign, logic [MAG_W-1:0] rmag,
                                       bit corrupt);
        logic [BYTE_W-1:0] body [FRAME_LEN-1];
        logic [BYTE_W-1:0] csum;
        body = '{HDR_BYTE, HDR_BYTE, lsign, lmag[23:16], lmag[15:8], lmag[7:0],
                 rsign, rmag[23:16], rmag[15:8], rmag[7:0]};
        csum = '0;
        foreach (body[i]) begin
            csum += body[i];
            rx_q.push_back(body[i]);
        end
        if (corrupt) csum ^= 8'($urandom_range(1, 255));
        rx_q.push_back(csum);
    endfunction

    function automatic void build_stimulus();
        int target;
        int n;
        // negative zero on the left, largest positive on the right
        push_frame(8'h00, 24'h000000, 8'h01, 24'hFFFFFF, 1'b0);
        // largest positive left, largest negative right; header bytes in the payload
        push_frame(8'hFF, 24'hFFFFFF, 8'h00, 24'hFFFFFF, 1'b0);
        target = rx_q.size() + RANDOM_ITEMS;
        while (rx_q.size() < target) begin
            case ($urandom_range(0, 9))
                7: begin
                    push_frame(pick_sign(), {pick_byte(), pick_byte(), pick_byte()},
                               pick_sign(), {pick_byte(), pick_byte(), pick_byte()}, 1'b1);
                end
                8: begin
                    // line noise
                    n = $urandom_range(1, 5);
                    repeat (n) rx_q.push_back(pick_byte());
                end
                9: begin
                    // header followed by a cut-off frame
                    rx_q.push_back(HDR_BYTE);
                    rx_q.push_back(HDR_BYTE);
                    n = $urandom_range(0, 8);
                    repeat (n) rx_q.push_back(pick_byte());
                end
                default: begin
                    push_frame(pick_sign(), {pick_byte(), pick_byte(), pick_byte()},
                               pick_sign(), {pick_byte(), pick_byte(), pick_byte()}, 1'b0);
                end
            endcase
        end
    endfunction

    // offer one byte and wait for the request to be taken
    task automatic send_byte(logic [BYTE_W-1:0] rx);
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        board.note_byte(rx);
    endtask

    // bursts of random length with random gaps
    task automatic drive_stream();
        int burst_left;
        int gap;
        burst_left = 0;
        foreach (rx_q[i]) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 24);
            end
            send_byte(rx_q[i]);
            burst_left--;
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        build_stimulus();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        drive_stream();
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
rtl/wfd_pkg.sv
rtl/wfd_window.sv
rtl/wfd_check.sv
rtl/wheel_feedback_frame_deframer_core.sv
sim/testbench.sv
